// ----- design/tedup_pkg.sv -----
// Shared types and constants for the triangle edge dedup unit.
// Used by the top level, tedup_ctrl and tedup_chk; depends on nothing.
package tedup_pkg;

  localparam int unsigned EDGE_CAPACITY = 4096;

  localparam logic [1:0] CFG_IDX_MODE = 2'd0;
  localparam logic [1:0] CFG_IDX_SIZE = 2'd1;

  localparam logic [1:0] SIZE_8  = 2'd0;
  localparam logic [1:0] SIZE_16 = 2'd1;
  localparam logic [1:0] SIZE_32 = 2'd2;

  localparam int unsigned CNT_W   = 13;
  localparam int unsigned CNT_MAX = 8191;

  typedef struct packed {
    logic [31:0] vertex_a;
    logic [31:0] vertex_b;
    logic [31:0] vertex_c;
    logic        start_mesh;
    logic        last_face;
  } in_t;

  typedef struct packed {
    logic [31:0]      edge_low;
    logic [31:0]      edge_high;
    logic             edge_valid;
    logic             overflow;
    logic [CNT_W-1:0] edge_count;
    logic             last_result;
  } out_t;

  typedef struct packed {
    logic       indexed_mode;
    logic [1:0] index_size;
  } cfg_t;

  function automatic logic [31:0] cut_index(logic [1:0] size, logic [31:0] v);
    logic [31:0] r;
    case (size)
      SIZE_8:  r = {24'd0, v[7:0]};
      SIZE_16: r = {16'd0, v[15:0]};
      SIZE_32: r = v;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- design/triangle_edge_dedup_unit.sv -----
// Per triangle: accept, then per edge the states HASH, RD, CHK and NEXT, with RD and
// CHK again per extra hash probe and a PUSH per result beat, then FIN; PUSH waits while
// the output stalls. A full table probes up to EdgeCapacity entries per edge.
// start_mesh adds a sweep of all EdgeCapacity table entries before the triangle.
// Reset: config to defaults, then a sweep of all EdgeCapacity entries with input stalled.
module triangle_edge_dedup_unit #(
  parameter int unsigned EdgeCapacity = tedup_pkg::EDGE_CAPACITY
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  tedup_pkg::in_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output tedup_pkg::out_t out_data_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [1:0]      cfg_index_i,
  input  logic [1:0]      cfg_data_i
);

  localparam int unsigned AW = $clog2(EdgeCapacity);

  tedup_pkg::cfg_t cfg_q, cfg_d;
  logic            ram_we;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [64:0]     ram_wdata, ram_rdata;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        tedup_pkg::CFG_IDX_MODE: cfg_d.indexed_mode = cfg_data_i[0];
        tedup_pkg::CFG_IDX_SIZE: cfg_d.index_size   = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{indexed_mode: 1'b1, index_size: tedup_pkg::SIZE_32};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  tedup_ctrl #(.EdgeCapacity(EdgeCapacity)) u_ctrl (
    .clk_i,
    .rst_ni,
    .cfg_i       (cfg_q),
    .in_valid_i,
    .in_stall_o,
    .in_data_i,
    .out_valid_o,
    .out_stall_i,
    .out_data_o,
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  tedup_ram #(.Width(65), .Depth(EdgeCapacity)) u_ram (
    .clk_i,
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

// ----- design/tedup_ram.sv -----
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module tedup_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- design/tedup_ctrl.sv -----
// Sequencer of the edge dedup unit: edge formation, hashed probing of the
// edge table, clearing sweep, result buffering. Depends on tedup_pkg.
module tedup_ctrl #(
  parameter int unsigned EdgeCapacity = tedup_pkg::EDGE_CAPACITY
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  tedup_pkg::cfg_t                 cfg_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  tedup_pkg::in_t                  in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output tedup_pkg::out_t                 out_data_o,
  output logic                            ram_we_o,
  output logic [$clog2(EdgeCapacity)-1:0] ram_waddr_o,
  output logic [64:0]                     ram_wdata_o,
  output logic [$clog2(EdgeCapacity)-1:0] ram_raddr_o,
  input  logic [64:0]                     ram_rdata_i
);

  localparam int unsigned AW = $clog2(EdgeCapacity);
  localparam int unsigned CW = $clog2(EdgeCapacity + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLEAR = 3'd1;
  localparam logic [2:0] S_HASH  = 3'd2;
  localparam logic [2:0] S_RD    = 3'd3;
  localparam logic [2:0] S_CHK   = 3'd4;
  localparam logic [2:0] S_NEXT  = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;
  localparam logic [2:0] S_PUSH  = 3'd7;

  logic [2:0]      st_q, st_d, ret_q, ret_d;
  logic [AW-1:0]   clr_q, clr_d, addr_q, addr_d;
  logic            clr_go_q, clr_go_d;
  logic [31:0]     fc_q, fc_d;
  logic [CW-1:0]   cnt_q, cnt_d, probe_q, probe_d;
  logic            ovf_q, ovf_d, last_q, last_d;
  logic [31:0]     elo_q [3];
  logic [31:0]     elo_d [3];
  logic [31:0]     ehi_q [3];
  logic [31:0]     ehi_d [3];
  logic [1:0]      eidx_q, eidx_d;
  tedup_pkg::out_t pend_q, pend_d, push_q, push_d, out_q, out_d;
  logic            pend_v_q, pend_v_d, out_v_q, out_v_d;

  logic [31:0]   cur_lo, cur_hi, mix, fc_eff, va, vb, vc, base;
  logic [31:0]   ea [3];
  logic [31:0]   eb [3];
  logic [AW-1:0] fold, home, addr_nx;
  logic [CW-1:0] cnt_inc;
  logic          rd_v, rd_hit;

  function automatic logic [tedup_pkg::CNT_W-1:0] sat_cnt(logic [CW-1:0] v);
    return (32'(v) > 32'(tedup_pkg::CNT_MAX)) ? tedup_pkg::CNT_W'(tedup_pkg::CNT_MAX)
                                               : tedup_pkg::CNT_W'(v);
  endfunction

  always_comb begin
    fc_eff = in_data_i.start_mesh ? 32'd0 : fc_q;
    base   = fc_eff + {fc_eff[30:0], 1'b0};
    va     = tedup_pkg::cut_index(cfg_i.index_size, in_data_i.vertex_a);
    vb     = tedup_pkg::cut_index(cfg_i.index_size, in_data_i.vertex_b);
    vc     = tedup_pkg::cut_index(cfg_i.index_size, in_data_i.vertex_c);
    if (cfg_i.indexed_mode) begin
      ea[0] = va; eb[0] = vb;
      ea[1] = vb; eb[1] = vc;
      ea[2] = vc; eb[2] = va;
    end else begin
      ea[0] = base;         eb[0] = base + 32'd1;
      ea[1] = base + 32'd1; eb[1] = base + 32'd2;
      ea[2] = base;         eb[2] = base + 32'd2;
    end
  end

  always_comb begin
    cur_lo  = elo_q[eidx_q];
    cur_hi  = ehi_q[eidx_q];
    mix     = cur_lo ^ {cur_hi[18:0], cur_hi[31:19]};
    fold    = mix[AW-1:0] ^ AW'(mix >> AW);
    home    = ({1'b0, fold} >= (AW+1)'(EdgeCapacity)) ? fold - AW'(EdgeCapacity) : fold;
    addr_nx = (addr_q == AW'(EdgeCapacity - 1)) ? '0 : addr_q + 1'b1;
    cnt_inc = cnt_q + 1'b1;
    rd_v    = ram_rdata_i[64];
    rd_hit  = rd_v && (ram_rdata_i[63:32] == cur_lo) && (ram_rdata_i[31:0] == cur_hi);
  end

  always_comb begin
    st_d     = st_q;
    ret_d    = ret_q;
    clr_d    = clr_q;
    clr_go_d = clr_go_q;
    addr_d   = addr_q;
    fc_d     = fc_q;
    cnt_d    = cnt_q;
    probe_d  = probe_q;
    ovf_d    = ovf_q;
    last_d   = last_q;
    elo_d    = elo_q;
    ehi_d    = ehi_q;
    eidx_d   = eidx_q;
    pend_d   = pend_q;
    pend_v_d = pend_v_q;
    push_d   = push_q;
    out_d    = out_q;
    out_v_d  = out_v_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = addr_q;
    ram_wdata_o = {1'b1, cur_lo, cur_hi};
    ram_raddr_o = addr_q;

    if (out_v_q && !out_stall_i) begin
      out_v_d = 1'b0;
    end

    case (st_q)
      S_IDLE: begin
        if (in_valid_i) begin
          for (int k = 0; k < 3; k++) begin
            elo_d[k] = (ea[k] < eb[k]) ? ea[k] : eb[k];
            ehi_d[k] = (ea[k] < eb[k]) ? eb[k] : ea[k];
          end
          fc_d   = fc_eff + 32'd1;
          last_d = in_data_i.last_face;
          eidx_d = 2'd0;
          if (in_data_i.start_mesh) begin
            cnt_d    = '0;
            ovf_d    = 1'b0;
            clr_d    = '0;
            clr_go_d = 1'b1;
            st_d     = S_CLEAR;
          end else begin
            st_d = S_HASH;
          end
        end
      end
      S_CLEAR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = clr_q;
        ram_wdata_o = '0;
        clr_d       = clr_q + 1'b1;
        if (clr_q == AW'(EdgeCapacity - 1)) begin
          st_d = clr_go_q ? S_HASH : S_IDLE;
        end
      end
      S_HASH: begin
        addr_d  = home;
        probe_d = '0;
        st_d    = S_RD;
      end
      S_RD: begin
        st_d = S_CHK;
      end
      S_CHK: begin
        st_d = S_NEXT;
        if (!rd_hit) begin
          if (!rd_v) begin
            if (32'(cnt_q) >= 32'(EdgeCapacity)) begin
              ovf_d = 1'b1;
            end else begin
              ram_we_o = 1'b1;
              cnt_d    = cnt_inc;
              pend_d   = '{edge_low: cur_lo, edge_high: cur_hi, edge_valid: 1'b1,
                           overflow: ovf_q, edge_count: sat_cnt(cnt_inc),
                           last_result: 1'b0};
              pend_v_d = 1'b1;
              if (pend_v_q) begin
                push_d = pend_q;
                ret_d  = S_NEXT;
                st_d   = S_PUSH;
              end
            end
          end else if (32'(probe_q) + 32'd1 >= 32'(EdgeCapacity)) begin
            ovf_d = 1'b1;
          end else begin
            addr_d  = addr_nx;
            probe_d = probe_q + 1'b1;
            st_d    = S_RD;
          end
        end
      end
      S_NEXT: begin
        if (eidx_q == 2'd2) begin
          st_d = S_FIN;
        end else begin
          eidx_d = eidx_q + 2'd1;
          st_d   = S_HASH;
        end
      end
      S_FIN: begin
        ret_d = S_IDLE;
        if (pend_v_q) begin
          push_d             = pend_q;
          push_d.last_result = last_q;
          pend_v_d           = 1'b0;
          st_d               = S_PUSH;
        end else if (last_q) begin
          push_d = '{edge_low: '0, edge_high: '0, edge_valid: 1'b0, overflow: ovf_q,
                     edge_count: sat_cnt(cnt_q), last_result: 1'b1};
          st_d   = S_PUSH;
        end else begin
          st_d = S_IDLE;
        end
      end
      S_PUSH: begin
        if (!out_v_q || !out_stall_i) begin
          out_d   = push_q;
          out_v_d = 1'b1;
          st_d    = ret_q;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= S_CLEAR;
      ret_q    <= S_IDLE;
      clr_q    <= '0;
      clr_go_q <= 1'b0;
      fc_q     <= '0;
      cnt_q    <= '0;
      ovf_q    <= 1'b0;
      eidx_q   <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      st_q     <= st_d;
      ret_q    <= ret_d;
      clr_q    <= clr_d;
      clr_go_q <= clr_go_d;
      fc_q     <= fc_d;
      cnt_q    <= cnt_d;
      ovf_q    <= ovf_d;
      eidx_q   <= eidx_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q  <= addr_d;
    probe_q <= probe_d;
    last_q  <= last_d;
    elo_q   <= elo_d;
    ehi_q   <= ehi_d;
    pend_q  <= pend_d;
    push_q  <= push_d;
    out_q   <= out_d;
  end

  assign in_stall_o  = (st_q != S_IDLE);
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

// ----- design/tedup_chk.sv -----
// Port-level checks for triangle_edge_dedup_unit, bound to the top level.
// Depends on tedup_pkg.
module tedup_chk (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_stall_o,
  input logic            out_valid_o,
  input logic            out_stall_i,
  input tedup_pkg::out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output beat changed");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while previous triangle in flight");

  a_marker_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.edge_valid |->
      out_data_o.last_result && out_data_o.edge_low == 32'd0 &&
      out_data_o.edge_high == 32'd0)
    else $error("malformed end marker");

  a_edge_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.edge_valid |->
      out_data_o.edge_low <= out_data_o.edge_high && out_data_o.edge_count != '0)
    else $error("edge beat not ordered or count zero");

endmodule

bind triangle_edge_dedup_unit tedup_chk u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
